@@ design/hrf_pkg.sv @@
// Shared types and constants for the HTTP response framer.
package hrf_pkg;

    parameter int HEADER_BYTES_DEF = 512;
    parameter int QUEUE_DEPTH      = 2;
    parameter int KW_LEN           = 15;

    // "Content-Length:"
    parameter logic [7:0] KW_TEXT [KW_LEN] = '{
        8'h43, 8'h6F, 8'h6E, 8'h74, 8'h65, 8'h6E, 8'h74, 8'h2D,
        8'h4C, 8'h65, 8'h6E, 8'h67, 8'h74, 8'h68, 8'h3A
    };

    parameter logic [7:0] CHAR_CR    = 8'h0D;
    parameter logic [7:0] CHAR_LF    = 8'h0A;
    parameter logic [7:0] CHAR_SPACE = 8'h20;
    parameter logic [7:0] CHAR_ZERO  = 8'h30;
    parameter logic [7:0] CHAR_NINE  = 8'h39;

    typedef struct packed {
        logic              is_cr;
        logic              is_lf;
        logic              is_space;
        logic              is_digit;
        logic [3:0]        digit;
        logic [KW_LEN-1:0] kw_hit;
    } item_t;

endpackage

@@ design/hrf_front.sv @@
// Front end: accepts received bytes and classifies them for the framer.
module hrf_front
(
    input  logic          rx_valid,
    output logic          rx_ready,
    input  logic [7:0]    rx_byte,
    output logic          push,
    output hrf_pkg::item_t push_item,
    input  logic          q_full
);

    logic [7:0] digit_raw;

    assign rx_ready  = !q_full;
    assign push      = rx_valid && !q_full;
    assign digit_raw = rx_byte - hrf_pkg::CHAR_ZERO;

    always_comb
    begin
        push_item.is_cr    = (rx_byte == hrf_pkg::CHAR_CR);
        push_item.is_lf    = (rx_byte == hrf_pkg::CHAR_LF);
        push_item.is_space = (rx_byte == hrf_pkg::CHAR_SPACE);
        push_item.is_digit = (rx_byte >= hrf_pkg::CHAR_ZERO) &&
                             (rx_byte <= hrf_pkg::CHAR_NINE);
        push_item.digit    = digit_raw[3:0];
        for (int i = 0; i < hrf_pkg::KW_LEN; i++)
        begin
            push_item.kw_hit[i] = (rx_byte == hrf_pkg::KW_TEXT[i]);
        end
    end

endmodule

@@ design/hrf_queue.sv @@
// Short FIFO of classified bytes between front end and framer.
module hrf_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  hrf_pkg::item_t push_item,
    output logic           full,
    output logic           head_valid,
    output hrf_pkg::item_t head_item,
    input  logic           pop
);

    localparam int PTR_W = (hrf_pkg::QUEUE_DEPTH > 1) ? $clog2(hrf_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(hrf_pkg::QUEUE_DEPTH + 1);

    hrf_pkg::item_t slot_reg [hrf_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_W'(hrf_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(hrf_pkg::QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(hrf_pkg::QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(hrf_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !head_valid |-> !pop)
        else $error("pop from empty queue");
`endif

endmodule

@@ design/hrf_back.sv @@
// Framer back end: header scan, length parse, body count and result register.
module hrf_back
#(
    parameter int HEADER_BYTES = hrf_pkg::HEADER_BYTES_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  hrf_pkg::item_t q_item,
    output logic           q_pop,
    output logic           res_valid,
    input  logic           res_ready,
    output logic           header_done,
    output logic           response_done,
    output logic           close_request,
    output logic [31:0]    body_length
);

    localparam int HC_W = $clog2(HEADER_BYTES + 1);

    localparam logic [4:0] POS_IDLE   = 5'd0;
    localparam logic [4:0] POS_SPACES = 5'd15;
    localparam logic [4:0] POS_DIGITS = 5'd16;

    // blank-line tracker codes
    localparam logic [2:0] NL_NONE     = 3'd0;
    localparam logic [2:0] NL_CR       = 3'd1;
    localparam logic [2:0] NL_CRLF     = 3'd2;
    localparam logic [2:0] NL_CRLFCR   = 3'd3;
    localparam logic [2:0] NL_LF       = 3'd4;

    logic            in_body_reg, in_body_next;
    logic [4:0]      kw_pos_reg, kw_pos_next;
    logic            line_start_reg, line_start_next;
    logic [2:0]      nl_reg, nl_next;
    logic [31:0]     length_reg, length_next;
    logic [HC_W-1:0] hdr_cnt_reg, hdr_cnt_next;
    logic [31:0]     body_cnt_reg, body_cnt_next;

    logic            res_valid_reg, res_valid_next;
    logic            hdone_reg, hdone_next;
    logic            rdone_reg, rdone_next;
    logic            close_reg, close_next;
    logic [31:0]     len_out_reg, len_out_next;

    logic            hdr_end;
    logic            clear;
    logic [35:0]     len_x10;
    logic [31:0]     len_digit;
    logic [31:0]     body_inc;
    logic [HC_W-1:0] hdr_inc;

    assign q_pop = q_valid && (!res_valid_reg || res_ready);

    assign res_valid     = res_valid_reg;
    assign header_done   = hdone_reg;
    assign response_done = rdone_reg;
    assign close_request = close_reg;
    assign body_length   = len_out_reg;

    // length * 10 + digit, saturating
    assign len_x10   = {1'b0, length_reg, 3'b000} + {3'b000, length_reg, 1'b0}
                     + {32'd0, q_item.digit};
    assign len_digit = (len_x10[35:32] != 4'd0) ? 32'hFFFF_FFFF : len_x10[31:0];
    assign body_inc  = (body_cnt_reg != 32'hFFFF_FFFF) ? body_cnt_reg + 32'd1
                     : body_cnt_reg;
    assign hdr_inc   = hdr_cnt_reg + HC_W'(1);

    always_comb
    begin
        in_body_next    = in_body_reg;
        kw_pos_next     = kw_pos_reg;
        line_start_next = line_start_reg;
        nl_next         = nl_reg;
        length_next     = length_reg;
        hdr_cnt_next    = hdr_cnt_reg;
        body_cnt_next   = body_cnt_reg;
        hdr_end         = 1'b0;
        clear           = 1'b0;
        hdone_next      = 1'b0;
        rdone_next      = 1'b0;
        close_next      = 1'b0;
        len_out_next    = length_reg;

        if (in_body_reg)
        begin
            body_cnt_next = body_inc;
            if (body_inc >= length_reg)
            begin
                rdone_next = 1'b1;
                clear      = 1'b1;
            end
        end
        else
        begin
            // blank-line detection
            if (q_item.is_cr)
            begin
                nl_next = (nl_reg == NL_CRLF) ? NL_CRLFCR : NL_CR;
            end
            else if (q_item.is_lf)
            begin
                if (nl_reg == NL_CR)
                begin
                    nl_next = NL_CRLF;
                end
                else if (nl_reg == NL_CRLFCR || nl_reg == NL_LF)
                begin
                    hdr_end = 1'b1;
                end
                else if (nl_reg == NL_NONE)
                begin
                    nl_next = NL_LF;
                end
                else
                begin
                    nl_next = NL_NONE;
                end
            end
            else
            begin
                nl_next = NL_NONE;
            end

            // keyword and number scan
            if (q_item.is_cr || q_item.is_lf)
            begin
                kw_pos_next     = POS_IDLE;
                line_start_next = 1'b1;
            end
            else
            begin
                line_start_next = 1'b0;
                if (kw_pos_reg >= 5'd1 && kw_pos_reg < POS_SPACES)
                begin
                    if (q_item.kw_hit[kw_pos_reg[3:0]])
                    begin
                        kw_pos_next = kw_pos_reg + 5'd1;
                        if (kw_pos_reg == POS_SPACES - 5'd1)
                        begin
                            length_next = 32'd0;
                        end
                    end
                    else
                    begin
                        kw_pos_next = POS_IDLE;
                    end
                end
                else if (kw_pos_reg == POS_SPACES)
                begin
                    if (q_item.is_digit)
                    begin
                        kw_pos_next = POS_DIGITS;
                        length_next = len_digit;
                    end
                    else if (!q_item.is_space)
                    begin
                        kw_pos_next = POS_IDLE;
                    end
                end
                else if (kw_pos_reg == POS_DIGITS)
                begin
                    if (q_item.is_digit)
                    begin
                        length_next = len_digit;
                    end
                    else
                    begin
                        kw_pos_next = POS_IDLE;
                    end
                end
                else if (kw_pos_reg == POS_IDLE && line_start_reg)
                begin
                    kw_pos_next = q_item.kw_hit[0] ? 5'd1 : POS_IDLE;
                end
                else
                begin
                    kw_pos_next = POS_IDLE;
                end
            end

            len_out_next = length_next;

            if (hdr_end)
            begin
                hdone_next = 1'b1;
                if (length_next == 32'd0)
                begin
                    close_next = 1'b1;
                    clear      = 1'b1;
                end
                else
                begin
                    in_body_next    = 1'b1;
                    body_cnt_next   = 32'd0;
                    hdr_cnt_next    = '0;
                    kw_pos_next     = POS_IDLE;
                    line_start_next = 1'b1;
                    nl_next         = NL_NONE;
                end
            end
            else
            begin
                hdr_cnt_next = hdr_inc;
                if (hdr_inc >= HC_W'(HEADER_BYTES))
                begin
                    close_next = 1'b1;
                    clear      = 1'b1;
                end
            end
        end

        if (clear)
        begin
            in_body_next    = 1'b0;
            kw_pos_next     = POS_IDLE;
            line_start_next = 1'b1;
            nl_next         = NL_NONE;
            length_next     = 32'd0;
            hdr_cnt_next    = '0;
            body_cnt_next   = 32'd0;
        end

        if (q_pop)
        begin
            res_valid_next = 1'b1;
        end
        else
        begin
            res_valid_next = res_valid_reg && !res_ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_body_reg    <= 1'b0;
            kw_pos_reg     <= POS_IDLE;
            line_start_reg <= 1'b1;
            nl_reg         <= NL_NONE;
            length_reg     <= 32'd0;
            hdr_cnt_reg    <= '0;
            body_cnt_reg   <= 32'd0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (q_pop)
            begin
                in_body_reg    <= in_body_next;
                kw_pos_reg     <= kw_pos_next;
                line_start_reg <= line_start_next;
                nl_reg         <= nl_next;
                length_reg     <= length_next;
                hdr_cnt_reg    <= hdr_cnt_next;
                body_cnt_reg   <= body_cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            hdone_reg   <= hdone_next;
            rdone_reg   <= rdone_next;
            close_reg   <= close_next;
            len_out_reg <= len_out_next;
        end
    end

`ifndef ASSERT_OFF
    a_done_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && rdone_reg) |-> (!hdone_reg && !close_reg))
        else $error("response done together with header done or close");
    a_body_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && hdone_reg && !close_reg) |-> (len_out_reg != 32'd0))
        else $error("body phase entered with zero length");
    a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && (rdone_next || close_next)) |=>
        (!in_body_reg && length_reg == 32'd0 && line_start_reg))
        else $error("framer not re-armed after completion or close");
    a_body_clean: assert property (@(posedge clk) disable iff (!rst_n)
        in_body_reg |-> (hdr_cnt_reg == '0 && kw_pos_reg == POS_IDLE))
        else $error("header scan state live during body");
`endif

endmodule

@@ design/http_response_framer_unit.sv @@
// Top level of the HTTP response framer: front end, queue and framer back end.
// A byte is written into the queue at the edge that accepts it; the framer step then writes its
// result into the result register, and that step waits while an earlier result is held by res_ready low.
// Throughput: one byte per cycle while no result is held; the framer back end updates all its state in a single step.
// Reset: asynchronous, active low; the framer returns to the header phase with no length,
// queue and result register empty. There is no clearing pass.
module http_response_framer_unit
#(
    parameter int HEADER_BYTES = hrf_pkg::HEADER_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rx_valid,
    output logic        rx_ready,
    input  logic [7:0]  rx_byte,
    output logic        res_valid,
    input  logic        res_ready,
    output logic        header_done,
    output logic        response_done,
    output logic        close_request,
    output logic [31:0] body_length
);

    logic           push;
    logic           q_full;
    logic           q_valid;
    logic           q_pop;
    hrf_pkg::item_t push_item;
    hrf_pkg::item_t head_item;

    hrf_front u_front
    (
        .rx_valid  (rx_valid),
        .rx_ready  (rx_ready),
        .rx_byte   (rx_byte),
        .push      (push),
        .push_item (push_item),
        .q_full    (q_full)
    );

    hrf_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (q_full),
        .head_valid (q_valid),
        .head_item  (head_item),
        .pop        (q_pop)
    );

    hrf_back
    #(
        .HEADER_BYTES (HEADER_BYTES)
    )
    u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_item        (head_item),
        .q_pop         (q_pop),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .header_done   (header_done),
        .response_done (response_done),
        .close_request (close_request),
        .body_length   (body_length)
    );

endmodule
